FILE: src/tpd_pkg.sv
package tpd_pkg;

    // default sizing
    localparam int MAX_NODES_DEF  = 1024;
    localparam int LOG_LEVELS_DEF = 10;

    // field widths
    localparam int TYPE_W = 2;
    localparam int IDX_W  = 10;
    localparam int LEN_W  = 30;
    localparam int DIST_W = 40;
    localparam int PATH_W = 41;
    localparam int STAT_W = 2;

    // request codes
    localparam logic [TYPE_W-1:0] REQ_NEW   = 2'd0;
    localparam logic [TYPE_W-1:0] REQ_ADD   = 2'd1;
    localparam logic [TYPE_W-1:0] REQ_QUERY = 2'd2;
    localparam logic [TYPE_W-1:0] REQ_SPARE = 2'd3;   // unused, answered as rejected query

    // status codes
    localparam logic [STAT_W-1:0] STAT_QUERY_OK  = 2'd0;
    localparam logic [STAT_W-1:0] STAT_ADD_OK    = 2'd1;
    localparam logic [STAT_W-1:0] STAT_ADD_REJ   = 2'd2;
    localparam logic [STAT_W-1:0] STAT_QUERY_REJ = 2'd3;

    typedef struct packed {
        logic [TYPE_W-1:0] req_type;
        logic [IDX_W-1:0]  parent;
        logic [LEN_W-1:0]  edge_length;
        logic [IDX_W-1:0]  node_a;
        logic [IDX_W-1:0]  node_b;
    } request_t;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [PATH_W-1:0] path_length;
        logic [IDX_W-1:0]  common_ancestor;
    } result_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_ADD_INFO,
        ST_ADD_LIFT,
        ST_Q_INFO,
        ST_Q_UP,
        ST_Q_UPW,
        ST_Q_EQ,
        ST_Q_CMP,
        ST_Q_PAR,
        ST_Q_DIST
    } ctrl_state_t;

endpackage

FILE: src/tree_path_distance_lca_unit.sv
// Weighted tree distance unit. Holds a rooted tree (node 0 is the root) as
// binary-lifting ancestor rows plus depth and root distance per node, and
// answers path-length / lowest-common-ancestor queries. A transaction is
// taken when start is high and busy is low; exactly one result comes back,
// on result with result_valid high for a single cycle, and the receiver
// cannot hold it off. A new transaction may start in the cycle the result
// is shown. The one sequencer steps through the ancestor RAM a level at
// a time (read data is registered): a new tree and every rejected
// transaction end at the request check; an add writes one ancestor level
// after another; a query lifts the deeper node by the set bits of the
// depth difference and, unless one node is an ancestor of the other,
// moves both nodes up, trying the levels from the top down, then takes
// the parent. The result is shown in the same cycle that busy falls.
// Memories need no clearing after reset: the root rows read as zero by
// construction, and only rows of nodes added since the last new-tree are
// ever read. Node indices above the field width cannot be named by a
// transaction.
module tree_path_distance_lca_unit
    import tpd_pkg::*;
    #(
        parameter int MAX_NODES  = MAX_NODES_DEF,
        parameter int LOG_LEVELS = LOG_LEVELS_DEF
    )
    (
        input  logic     clk,
        input  logic     rst_n,
        input  logic     start,
        input  request_t request,
        output logic     busy,
        output logic     result_valid,
        output result_t  result
    );

    localparam int NW = $clog2(MAX_NODES);
    localparam int LW = (LOG_LEVELS > 1) ? $clog2(LOG_LEVELS) : 1;
    localparam int IW = NW + DIST_W;   // {depth, root distance}

    // ancestor table port
    logic             anc_we;
    logic [NW+LW-1:0] anc_waddr;
    logic [NW-1:0]    anc_wdata;
    logic             anc_re;
    logic [NW+LW-1:0] anc_raddr0, anc_raddr1;
    logic [NW-1:0]    anc_rdata0, anc_rdata1;

    // per-node depth and distance port
    logic          info_we;
    logic [NW-1:0] info_waddr;
    logic [IW-1:0] info_wdata;
    logic          info_re;
    logic [NW-1:0] info_raddr0, info_raddr1;
    logic [IW-1:0] info_rdata0, info_rdata1;

    tpd_ctrl
        #(
            .MAX_NODES  (MAX_NODES),
            .LOG_LEVELS (LOG_LEVELS)
        )
    u_ctrl
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .request      (request),
        .busy         (busy),
        .result_valid (result_valid),
        .result       (result),
        .anc_we       (anc_we),
        .anc_waddr    (anc_waddr),
        .anc_wdata    (anc_wdata),
        .anc_re       (anc_re),
        .anc_raddr0   (anc_raddr0),
        .anc_raddr1   (anc_raddr1),
        .anc_rdata0   (anc_rdata0),
        .anc_rdata1   (anc_rdata1),
        .info_we      (info_we),
        .info_waddr   (info_waddr),
        .info_wdata   (info_wdata),
        .info_re      (info_re),
        .info_raddr0  (info_raddr0),
        .info_raddr1  (info_raddr1),
        .info_rdata0  (info_rdata0),
        .info_rdata1  (info_rdata1)
    );

    // ancestor rows, addressed {node, level}
    tpd_ram
        #(
            .ADDR_W (NW + LW),
            .DATA_W (NW)
        )
    u_anc_ram
    (
        .clk    (clk),
        .we     (anc_we),
        .waddr  (anc_waddr),
        .wdata  (anc_wdata),
        .re     (anc_re),
        .raddr0 (anc_raddr0),
        .raddr1 (anc_raddr1),
        .rdata0 (anc_rdata0),
        .rdata1 (anc_rdata1)
    );

    // depth and root distance, addressed by node
    tpd_ram
        #(
            .ADDR_W (NW),
            .DATA_W (IW)
        )
    u_info_ram
    (
        .clk    (clk),
        .we     (info_we),
        .waddr  (info_waddr),
        .wdata  (info_wdata),
        .re     (info_re),
        .raddr0 (info_raddr0),
        .raddr1 (info_raddr1),
        .rdata0 (info_rdata0),
        .rdata1 (info_rdata1)
    );

endmodule

FILE: src/tpd_ram.sv
// Simple dual-read, single-write RAM, registered read data.
module tpd_ram
    #(
        parameter int ADDR_W = 8,
        parameter int DATA_W = 8
    )
    (
        input  logic              clk,
        input  logic              we,
        input  logic [ADDR_W-1:0] waddr,
        input  logic [DATA_W-1:0] wdata,
        input  logic              re,
        input  logic [ADDR_W-1:0] raddr0,
        input  logic [ADDR_W-1:0] raddr1,
        output logic [DATA_W-1:0] rdata0,
        output logic [DATA_W-1:0] rdata1
    );

    logic [DATA_W-1:0] mem [0:(1 << ADDR_W)-1];
    logic [DATA_W-1:0] rdata0_reg;
    logic [DATA_W-1:0] rdata1_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata0_reg <= mem[raddr0];
            rdata1_reg <= mem[raddr1];
        end
    end

    assign rdata0 = rdata0_reg;
    assign rdata1 = rdata1_reg;

endmodule

FILE: src/tpd_alu.sv
// Shared add / subtract unit for distance sums.
module tpd_alu
    import tpd_pkg::*;
    (
        input  logic [PATH_W-1:0] x,
        input  logic [PATH_W-1:0] y,
        input  logic              sub,
        output logic [PATH_W-1:0] sum
    );

    assign sum = sub ? (x - y) : (x + y);

endmodule

FILE: src/tpd_ctrl.sv
// Sequencer and datapath registers: tree build and LCA walk.
module tpd_ctrl
    import tpd_pkg::*;
    #(
        parameter int MAX_NODES  = MAX_NODES_DEF,
        parameter int LOG_LEVELS = LOG_LEVELS_DEF,
        localparam int NW = $clog2(MAX_NODES),
        localparam int LW = (LOG_LEVELS > 1) ? $clog2(LOG_LEVELS) : 1,
        localparam int IW = NW + DIST_W
    )
    (
        input  logic             clk,
        input  logic             rst_n,
        input  logic             start,
        input  request_t         request,
        output logic             busy,
        output logic             result_valid,
        output result_t          result,
        output logic             anc_we,
        output logic [NW+LW-1:0] anc_waddr,
        output logic [NW-1:0]    anc_wdata,
        output logic             anc_re,
        output logic [NW+LW-1:0] anc_raddr0,
        output logic [NW+LW-1:0] anc_raddr1,
        input  logic [NW-1:0]    anc_rdata0,
        input  logic [NW-1:0]    anc_rdata1,
        output logic             info_we,
        output logic [NW-1:0]    info_waddr,
        output logic [IW-1:0]    info_wdata,
        output logic             info_re,
        output logic [NW-1:0]    info_raddr0,
        output logic [NW-1:0]    info_raddr1,
        input  logic [IW-1:0]    info_rdata0,
        input  logic [IW-1:0]    info_rdata1
    );

    localparam int CW    = $clog2(MAX_NODES + 1);
    localparam int CMP_W = (CW > IDX_W) ? CW : IDX_W;

    ctrl_state_t state_reg, state_next;

    request_t              req_reg, req_next;
    logic [CW-1:0]         cnt_reg, cnt_next;
    logic [NW-1:0]         a_reg, a_next;
    logic [NW-1:0]         b_reg, b_next;
    logic [LW-1:0]         lvl_reg, lvl_next;
    logic [LOG_LEVELS-1:0] diff_reg, diff_next;
    logic [PATH_W-1:0]     acc_reg, acc_next;
    result_t               res_reg, res_next;
    logic                  result_valid_reg, result_valid_next;

    // root rows are never written: flag reads of node 0 and force zero
    logic anc_z0_reg, anc_z1_reg, info_z0_reg, info_z1_reg;

    logic [NW-1:0]     anc_d0, anc_d1;
    logic [IW-1:0]     info_q0, info_q1;
    logic [NW-1:0]     depth_a, depth_b, depth_diff;
    logic [DIST_W-1:0] dist_a, dist_b;
    logic              add_ok, query_ok, lvl_last, lvl_first;
    logic [NW-1:0]     cmp_a, cmp_b;

    logic [PATH_W-1:0] alu_x, alu_y, alu_sum;
    logic              alu_sub;

    tpd_alu u_alu
    (
        .x   (alu_x),
        .y   (alu_y),
        .sub (alu_sub),
        .sum (alu_sum)
    );

    assign anc_d0  = anc_z0_reg  ? '0 : anc_rdata0;
    assign anc_d1  = anc_z1_reg  ? '0 : anc_rdata1;
    assign info_q0 = info_z0_reg ? '0 : info_rdata0;
    assign info_q1 = info_z1_reg ? '0 : info_rdata1;

    assign depth_a = info_q0[IW-1:DIST_W];
    assign depth_b = info_q1[IW-1:DIST_W];
    assign dist_a  = info_q0[DIST_W-1:0];
    assign dist_b  = info_q1[DIST_W-1:0];
    assign depth_diff = (depth_a >= depth_b) ? (depth_a - depth_b) : (depth_b - depth_a);

    assign add_ok = (cnt_reg < CW'(MAX_NODES))
                 && (CMP_W'(req_reg.parent) < CMP_W'(cnt_reg));
    assign query_ok = (CMP_W'(req_reg.node_a) < CMP_W'(cnt_reg))
                   && (CMP_W'(req_reg.node_b) < CMP_W'(cnt_reg));

    assign lvl_last  = (lvl_reg == LW'(LOG_LEVELS - 1));
    assign lvl_first = (lvl_reg == '0);

    // second pass: both jump only where the ancestors still differ
    assign cmp_a = (anc_d0 != anc_d1) ? anc_d0 : a_reg;
    assign cmp_b = (anc_d0 != anc_d1) ? anc_d1 : b_reg;

    assign busy         = (state_reg != ST_IDLE);
    assign result_valid = result_valid_reg;
    assign result       = res_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                case (req_reg.req_type)
                    REQ_NEW:   state_next = ST_IDLE;
                    REQ_ADD:   state_next = add_ok ? ST_ADD_INFO : ST_IDLE;
                    REQ_QUERY: state_next = query_ok ? ST_Q_INFO : ST_IDLE;
                    default:   state_next = ST_IDLE;
                endcase
            end
            ST_ADD_INFO:
            begin
                state_next = (LOG_LEVELS == 1) ? ST_IDLE : ST_ADD_LIFT;
            end
            ST_ADD_LIFT:
            begin
                if (lvl_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_Q_INFO:
            begin
                state_next = ST_Q_UP;
            end
            ST_Q_UP:
            begin
                if (diff_reg[lvl_reg])
                begin
                    state_next = ST_Q_UPW;
                end
                else if (lvl_last)
                begin
                    state_next = ST_Q_EQ;
                end
            end
            ST_Q_UPW:
            begin
                state_next = lvl_last ? ST_Q_EQ : ST_Q_UP;
            end
            ST_Q_EQ:
            begin
                state_next = (a_reg == b_reg) ? ST_Q_DIST : ST_Q_CMP;
            end
            ST_Q_CMP:
            begin
                if (lvl_first)
                begin
                    state_next = ST_Q_PAR;
                end
            end
            ST_Q_PAR:
            begin
                state_next = ST_Q_DIST;
            end
            ST_Q_DIST:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // datapath and memory control
    always_comb
    begin
        req_next          = req_reg;
        cnt_next          = cnt_reg;
        a_next            = a_reg;
        b_next            = b_reg;
        lvl_next          = lvl_reg;
        diff_next         = diff_reg;
        acc_next          = acc_reg;
        res_next          = res_reg;
        result_valid_next = 1'b0;

        anc_we      = 1'b0;
        anc_waddr   = '0;
        anc_wdata   = '0;
        anc_re      = 1'b0;
        anc_raddr0  = '0;
        anc_raddr1  = '0;
        info_we     = 1'b0;
        info_waddr  = '0;
        info_wdata  = '0;
        info_re     = 1'b0;
        info_raddr0 = '0;
        info_raddr1 = '0;

        alu_x   = '0;
        alu_y   = '0;
        alu_sub = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    req_next = request;
                end
            end
            ST_CHECK:
            begin
                case (req_reg.req_type)
                    REQ_NEW:
                    begin
                        cnt_next          = CW'(1);
                        result_valid_next = 1'b1;
                        res_next          = '{STAT_ADD_OK, '0, '0};
                    end
                    REQ_ADD:
                    begin
                        if (add_ok)
                        begin
                            info_re     = 1'b1;
                            info_raddr0 = NW'(req_reg.parent);
                            anc_re      = 1'b1;
                            anc_raddr0  = {NW'(req_reg.parent), LW'(0)};
                            anc_we      = 1'b1;
                            anc_waddr   = {NW'(cnt_reg), LW'(0)};
                            anc_wdata   = NW'(req_reg.parent);
                            lvl_next    = LW'(1);
                        end
                        else
                        begin
                            result_valid_next = 1'b1;
                            res_next          = '{STAT_ADD_REJ, '0, '0};
                        end
                    end
                    REQ_QUERY:
                    begin
                        if (query_ok)
                        begin
                            info_re     = 1'b1;
                            info_raddr0 = NW'(req_reg.node_a);
                            info_raddr1 = NW'(req_reg.node_b);
                            a_next      = NW'(req_reg.node_a);
                            b_next      = NW'(req_reg.node_b);
                        end
                        else
                        begin
                            result_valid_next = 1'b1;
                            res_next          = '{STAT_QUERY_REJ, '0, '0};
                        end
                    end
                    default:
                    begin
                        result_valid_next = 1'b1;
                        res_next          = '{STAT_QUERY_REJ, '0, '0};
                    end
                endcase
            end
            ST_ADD_INFO:
            begin
                // parent depth / distance are on read port 0
                alu_x      = PATH_W'(dist_a);
                alu_y      = PATH_W'(req_reg.edge_length);
                info_we    = 1'b1;
                info_waddr = NW'(cnt_reg);
                info_wdata = {depth_a + NW'(1), alu_sum[DIST_W-1:0]};
                if (LOG_LEVELS == 1)
                begin
                    cnt_next          = cnt_reg + CW'(1);
                    result_valid_next = 1'b1;
                    res_next          = '{STAT_ADD_OK, '0, '0};
                end
            end
            ST_ADD_LIFT:
            begin
                // anc_d0 is this level's ancestor, read from the row one level below
                anc_we    = 1'b1;
                anc_waddr = {NW'(cnt_reg), lvl_reg};
                anc_wdata = anc_d0;
                if (lvl_last)
                begin
                    cnt_next          = cnt_reg + CW'(1);
                    result_valid_next = 1'b1;
                    res_next          = '{STAT_ADD_OK, '0, '0};
                end
                else
                begin
                    anc_re     = 1'b1;
                    anc_raddr0 = {anc_d0, lvl_reg};
                    lvl_next   = lvl_reg + LW'(1);
                end
            end
            ST_Q_INFO:
            begin
                alu_x     = PATH_W'(dist_a);
                alu_y     = PATH_W'(dist_b);
                acc_next  = alu_sum;
                diff_next = LOG_LEVELS'(depth_diff);
                lvl_next  = '0;
                if (depth_a < depth_b)
                begin
                    a_next = b_reg;
                    b_next = a_reg;
                end
            end
            ST_Q_UP:
            begin
                if (diff_reg[lvl_reg])
                begin
                    anc_re     = 1'b1;
                    anc_raddr0 = {a_reg, lvl_reg};
                end
                else if (!lvl_last)
                begin
                    lvl_next = lvl_reg + LW'(1);
                end
            end
            ST_Q_UPW:
            begin
                a_next = anc_d0;
                if (!lvl_last)
                begin
                    lvl_next = lvl_reg + LW'(1);
                end
            end
            ST_Q_EQ:
            begin
                if (a_reg == b_reg)
                begin
                    info_re     = 1'b1;
                    info_raddr0 = a_reg;
                end
                else
                begin
                    lvl_next   = LW'(LOG_LEVELS - 1);
                    anc_re     = 1'b1;
                    anc_raddr0 = {a_reg, LW'(LOG_LEVELS - 1)};
                    anc_raddr1 = {b_reg, LW'(LOG_LEVELS - 1)};
                end
            end
            ST_Q_CMP:
            begin
                a_next = cmp_a;
                b_next = cmp_b;
                anc_re = 1'b1;
                if (lvl_first)
                begin
                    anc_raddr0 = {cmp_a, LW'(0)};
                end
                else
                begin
                    lvl_next   = lvl_reg - LW'(1);
                    anc_raddr0 = {cmp_a, lvl_reg - LW'(1)};
                    anc_raddr1 = {cmp_b, lvl_reg - LW'(1)};
                end
            end
            ST_Q_PAR:
            begin
                a_next      = anc_d0;
                info_re     = 1'b1;
                info_raddr0 = anc_d0;
            end
            ST_Q_DIST:
            begin
                alu_x             = acc_reg;
                alu_y             = {dist_a, 1'b0};
                alu_sub           = 1'b1;
                result_valid_next = 1'b1;
                res_next          = '{STAT_QUERY_OK, alu_sum, IDX_W'(a_reg)};
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            cnt_reg          <= CW'(1);
            lvl_reg          <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            cnt_reg          <= cnt_next;
            lvl_reg          <= lvl_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg  <= req_next;
        a_reg    <= a_next;
        b_reg    <= b_next;
        diff_reg <= diff_next;
        acc_reg  <= acc_next;
        res_reg  <= res_next;
        if (anc_re)
        begin
            anc_z0_reg <= (anc_raddr0[NW+LW-1:LW] == '0);
            anc_z1_reg <= (anc_raddr1[NW+LW-1:LW] == '0);
        end
        if (info_re)
        begin
            info_z0_reg <= (info_raddr0 == '0);
            info_z1_reg <= (info_raddr1 == '0);
        end
    end

    a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg |=> !result_valid_reg)
        else $error("result strobe longer than one cycle");

    a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg |-> (state_reg == ST_IDLE))
        else $error("result shown while sequencer busy");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg != '0) && (cnt_reg <= CW'(MAX_NODES)))
        else $error("node count out of range");

    a_lca_known: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_Q_DIST) |-> (CW'(a_reg) < cnt_reg))
        else $error("common ancestor is not a known node");

endmodule

FILE: dv/tree_path_distance_lca_unit_test.sv
`timescale 1ns / 100ps

import tpd_pkg::*;

// Scoreboard: keeps its own copy of the tree and works out the answer to
// every accepted transaction; results are checked in order against it.
class tree_distance_board;
    int unsigned     node_total;
    bit [IDX_W-1:0]  lift [MAX_NODES_DEF][LOG_LEVELS_DEF];
    bit [IDX_W-1:0]  level [MAX_NODES_DEF];
    bit [DIST_W-1:0] reach [MAX_NODES_DEF];
    result_t         awaited [$];
    int              mismatches;

    function new();
        node_total = 1;
        mismatches = 0;
        for (int k = 0; k < LOG_LEVELS_DEF; k++)
            lift[0][k] = '0;
        level[0] = '0;
        reach[0] = '0;
    endfunction

    // lowest common ancestor by binary lifting
    function bit [IDX_W-1:0] meet(bit [IDX_W-1:0] a, bit [IDX_W-1:0] b);
        bit [IDX_W-1:0] t;
        bit [IDX_W-1:0] gap;
        if (level[a] < level[b])
        begin
            t = a;
            a = b;
            b = t;
        end
        gap = level[a] - level[b];
        for (int k = 0; k < LOG_LEVELS_DEF; k++)
            if (gap[k])
                a = lift[a][k];
        if (a == b)
            return a;
        for (int k = LOG_LEVELS_DEF - 1; k >= 0; k--)
            if (lift[a][k] != lift[b][k])
            begin
                a = lift[a][k];
                b = lift[b][k];
            end
        return lift[a][0];
    endfunction

    function void note_request(request_t r);
        result_t           want;
        bit [IDX_W-1:0]    v;
        bit [IDX_W-1:0]    l;
        logic [PATH_W:0]   span;
        want = '0;
        want.status = STAT_QUERY_REJ;
        case (r.req_type)
            REQ_NEW:
            begin
                node_total = 1;
                want.status = STAT_ADD_OK;
            end
            REQ_ADD:
            begin
                if (node_total >= MAX_NODES_DEF || r.parent >= node_total)
                    want.status = STAT_ADD_REJ;
                else
                begin
                    v = node_total[IDX_W-1:0];
                    level[v] = level[r.parent] + 1'b1;
                    reach[v] = reach[r.parent] + r.edge_length;
                    lift[v][0] = r.parent;
                    for (int k = 1; k < LOG_LEVELS_DEF; k++)
                        lift[v][k] = lift[lift[v][k-1]][k-1];
                    node_total++;
                    want.status = STAT_ADD_OK;
                end
            end
            REQ_QUERY:
            begin
                if (r.node_a < node_total && r.node_b < node_total)
                begin
                    l = meet(r.node_a, r.node_b);
                    span = {2'b00, reach[r.node_a]} + {2'b00, reach[r.node_b]}
                           - {1'b0, reach[l], 1'b0};
                    want.status = STAT_QUERY_OK;
                    want.path_length = span[PATH_W-1:0];
                    want.common_ancestor = l;
                end
            end
            default: ;
        endcase
        awaited.insert(awaited.size(), want);
    endfunction

    function void check_result(result_t got);
        result_t want;
        if (awaited.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("%0t: result with nothing awaited: status %0d path %0d lca %0d",
                         $realtime, got.status, got.path_length,
                         got.common_ancestor);
            return;
        end
        want = awaited.pop_front();
        if (got.status !== want.status || got.path_length !== want.path_length
            || got.common_ancestor !== want.common_ancestor)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display({"%0t: mismatch: expected status %0d path %0d lca %0d,",
                          " got status %0d path %0d lca %0d"},
                         $realtime, want.status, want.path_length,
                         want.common_ancestor, got.status, got.path_length,
                         got.common_ancestor);
        end
    endfunction
endclass

module tree_path_distance_lca_unit_test;

    // No transaction and no result for this many cycles means a hang.
    localparam int STALL_LIMIT  = 1000;
    localparam int END_SETTLE   = 40;
    localparam int RANDOM_ITEMS = 650;

    logic     clk;
    logic     rst_n   = 1'b0;
    logic     start   = 1'b0;
    request_t request = '0;
    logic     busy;
    logic     result_valid;
    result_t  result;

    tree_distance_board board;
    bit                 gaps_on;
    int unsigned        items_sent;

    tree_path_distance_lca_unit uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .request      (request),
        .busy         (busy),
        .result_valid (result_valid),
        .result       (result)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Results cannot be held off, so every strobe is checked as it comes.
    always @(posedge clk)
        if (rst_n && result_valid === 1'b1)
            board.check_result(result);

    // Watchdog: counts cycles in which neither side moves a transaction.
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((start === 1'b1 && busy === 1'b0) || result_valid === 1'b1)
                quiet = 0;
            else
                quiet++;
        end
        $display("*** FAILED ***");
        $finish;
    end

    // Present one transaction and hold it until the block takes it. An
    // optional burst of idle cycles comes first, with start low. start is
    // left high on return so back-to-back transactions need no gap.
    task automatic send(logic [TYPE_W-1:0] kind, logic [IDX_W-1:0] par,
                        logic [LEN_W-1:0] len, logic [IDX_W-1:0] a,
                        logic [IDX_W-1:0] b);
        request_t r;
        r.req_type    = kind;
        r.parent      = par;
        r.edge_length = len;
        r.node_a      = a;
        r.node_b      = b;
        if (gaps_on && $urandom_range(0, 3) == 0)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clk);
        end
        request <= r;
        start   <= 1'b1;
        do
            @(posedge clk);
        while (busy);
        board.note_request(r);
        items_sent++;
    endtask

    // edge lengths lean towards the extremes
    function automatic logic [LEN_W-1:0] any_length();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return '1;
            2:       return LEN_W'($urandom_range(0, 15));
            default: return LEN_W'($urandom);
        endcase
    endfunction

    function automatic logic [IDX_W-1:0] any_index();
        return IDX_W'($urandom);
    endfunction

    function automatic logic [IDX_W-1:0] any_node();
        return IDX_W'($urandom_range(0, board.node_total - 1));
    endfunction

    function automatic logic [IDX_W-1:0] unknown_node();
        return IDX_W'($urandom_range(board.node_total, 1023));
    endfunction

    // parent choice: often the newest node, which grows deep chains
    function automatic logic [IDX_W-1:0] any_parent(int chain_pct);
        if ($urandom_range(0, 99) < chain_pct)
            return IDX_W'(board.node_total - 1);
        return any_node();
    endfunction

    // fully random transaction, any request code
    task automatic send_any();
        send(TYPE_W'($urandom), any_index(), LEN_W'($urandom), any_index(),
             any_index());
    endtask

    initial
    begin : stimulus
        int roll;
        int steps;
        board = new();
        gaps_on = 1'b1;
        items_sent = 0;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // ---- directed part ----
        gaps_on = 1'b0;
        send(REQ_QUERY, '1, '1, 10'd0, 10'd0);       // root against itself
        send(REQ_QUERY, '0, '0, 10'd0, 10'd1);       // unknown query node
        send(REQ_QUERY, '0, '0, '1, '1);             // highest indices
        send(REQ_SPARE, '1, '1, '1, '1);             // unused request code
        send(REQ_ADD, 10'd1, '1, '0, '0);            // unknown parent
        send(REQ_ADD, 10'd0, '1, '1, '1);            // node 1, longest edge
        send(REQ_ADD, 10'd1, '0, '0, '0);            // node 2, zero edge
        send(REQ_ADD, 10'd0, 30'd1, '0, '0);         // node 3
        send(REQ_ADD, 10'd2, '1, '0, '0);            // node 4
        send(REQ_QUERY, '0, '0, 10'd4, 10'd3);       // meet at the root
        send(REQ_QUERY, '1, '1, 10'd3, 10'd4);       // same, swapped
        send(REQ_QUERY, '0, '0, 10'd4, 10'd1);       // one is ancestor
        send(REQ_QUERY, '0, '0, 10'd0, 10'd4);
        send(REQ_QUERY, '0, '0, 10'd2, 10'd2);
        send(REQ_ADD, '1, '1, '0, '0);               // parent 1023, unknown
        send(REQ_QUERY, '0, '0, 10'd5, 10'd0);
        send(REQ_QUERY, '0, '0, 10'd0, 10'd5);
        send(REQ_NEW, '1, '1, '1, '1);               // new tree
        send(REQ_QUERY, '0, '0, 10'd1, 10'd0);       // old node now unreachable
        send(REQ_ADD, 10'd0, '1, '0, '0);            // node 1 rewritten
        send(REQ_QUERY, '0, '0, 10'd1, 10'd1);
        send(REQ_QUERY, '0, '0, 10'd1, 10'd0);
        send(REQ_SPARE, '0, '0, '0, '0);

        // ---- random trees: mostly small, now and then a larger one ----
        while (items_sent < RANDOM_ITEMS)
        begin
            gaps_on = ($urandom_range(0, 2) != 0);
            send(REQ_NEW, any_index(), LEN_W'($urandom), any_index(), any_index());
            steps = ($urandom_range(0, 7) == 0) ? $urandom_range(120, 400)
                                                : $urandom_range(4, 60);
            repeat (steps)
            begin
                roll = $urandom_range(0, 99);
                if (roll < 48)
                    send(REQ_ADD, any_parent(50), any_length(), any_index(),
                         any_index());
                else if (roll < 84)
                    send(REQ_QUERY, any_index(), LEN_W'($urandom), any_node(),
                         any_node());
                else if (roll < 88)
                    send(REQ_ADD, unknown_node(), any_length(), any_index(),
                         any_index());
                else if (roll < 93)
                    send(REQ_QUERY, any_index(), LEN_W'($urandom), any_node(),
                         unknown_node());
                else
                    send_any();
            end
        end

        // ---- fill one tree to the table limit, deep chains throughout ----
        gaps_on = 1'b1;
        send(REQ_NEW, any_index(), LEN_W'($urandom), any_index(), any_index());
        while (board.node_total < MAX_NODES_DEF)
        begin
            if ($urandom_range(0, 4) == 0)
                send(REQ_QUERY, any_index(), LEN_W'($urandom), any_node(),
                     any_node());
            else
                send(REQ_ADD, any_parent(75), any_length(), any_index(),
                     any_index());
        end
        send(REQ_ADD, 10'd0, '1, '0, '0);            // table full
        send(REQ_ADD, '1, LEN_W'($urandom), '0, '0); // table full, last parent
        send(REQ_QUERY, '0, '0, '1, 10'd0);
        send(REQ_QUERY, '0, '0, 10'd0, '1);

        // ---- closing stretch: no idling, mostly queries, starting on the full tree ----
        gaps_on = 1'b0;
        repeat (150)
        begin
            if ($urandom_range(0, 9) == 0)
                send_any();
            else
                send(REQ_QUERY, any_index(), LEN_W'($urandom), any_node(),
                     any_node());
        end
        start <= 1'b0;

        // drain, then allow for any stray strobe
        while (board.awaited.size() != 0)
            @(posedge clk);
        repeat (END_SETTLE) @(posedge clk);

        if (board.mismatches == 0 && board.awaited.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

FILE: files.f
src/tpd_pkg.sv
src/tpd_ram.sv
src/tpd_alu.sv
src/tpd_ctrl.sv
src/tree_path_distance_lca_unit.sv
dv/tree_path_distance_lca_unit_test.sv
